// ===== hdl/fast_vector_normalize_macros.svh =====
// assertion macros for the fast vector normalize block
// used by the top level; needs nothing else
`ifndef FAST_VECTOR_NORMALIZE_MACROS_SVH
`define FAST_VECTOR_NORMALIZE_MACROS_SVH
`ifndef SYNTHESIS
`define FVN_ASSERT_IMP(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define FVN_ASSERT_NXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define FVN_ASSERT_IMP(lbl, clk, rst_n, cond, prop)
`define FVN_ASSERT_NXT(lbl, clk, rst_n, cond, prop)
`endif
`endif

// ===== hdl/fvn_pkg.sv =====
// types, constants and binary32 helper functions for the vector normalize block
// no dependencies
package fvn_pkg;

    localparam logic [31:0] MAGIC_WORD   = 32'h5f3759df;
    localparam logic [31:0] ONE_HALF     = 32'h3F000000;
    localparam logic [31:0] THREE_HALVES = 32'h3FC00000;
    localparam logic [31:0] CANON_NAN    = 32'h7FC00000;

    typedef struct packed {
        logic [31:0] x_bits;
        logic [31:0] y_bits;
    } vec_t;

    typedef struct packed {
        logic [31:0] norm_x_bits;
        logic [31:0] norm_y_bits;
        logic [31:0] inv_len_bits;
    } res_t;

    // adder state between alignment and normalization
    typedef struct packed {
        logic               special;
        logic [31:0]        special_val;
        logic               sign;
        logic signed [10:0] exp;
        logic [27:0]        sum;
    } add_mid_t;

    // flush subnormals, canonicalize nan
    function automatic logic [31:0] fp_tidy(input logic [31:0] b);
        if (b[30:23] == 8'h00)
            return {b[31], 31'b0};
        if (b[30:23] == 8'hFF && b[22:0] != 23'b0)
            return CANON_NAN;
        return b;
    endfunction

    // round to nearest even, flush subnormal results
    function automatic logic [31:0] fp_round(input logic s, input logic signed [10:0] e,
                                             input logic [23:0] m, input logic g,
                                             input logic st);
        logic [24:0]        m25;
        logic signed [10:0] er;
        // just below the smallest normal: coarser subnormal rounding reaches it
        if (e == 11'sd0 && m == 24'hFFFFFF)
            return {s, 8'h01, 23'b0};
        m25 = {1'b0, m} + 25'(g & (st | m[0]));
        er  = e;
        if (m25[24])
        begin
            er  = e + 11'sd1;
            m25 = m25 >> 1;
        end
        if (er <= 11'sd0)
            return {s, 31'b0};
        if (er >= 11'sd255)
            return {s, 8'hFF, 23'b0};
        return {s, er[7:0], m25[22:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]        ta;
        logic [31:0]        tb;
        logic               s;
        logic               a_inf;
        logic               b_inf;
        logic               a_zero;
        logic               b_zero;
        logic [47:0]        p;
        logic signed [10:0] e;
        logic [23:0]        m;
        logic               g;
        logic               st;
        ta     = fp_tidy(a);
        tb     = fp_tidy(b);
        s      = ta[31] ^ tb[31];
        a_inf  = ta[30:23] == 8'hFF && ta[22:0] == 23'b0;
        b_inf  = tb[30:23] == 8'hFF && tb[22:0] == 23'b0;
        a_zero = ta[30:23] == 8'h00;
        b_zero = tb[30:23] == 8'h00;
        if (ta == CANON_NAN || tb == CANON_NAN || (a_inf && b_zero) || (b_inf && a_zero))
            return CANON_NAN;
        if (a_inf || b_inf)
            return {s, 8'hFF, 23'b0};
        if (a_zero || b_zero)
            return {s, 31'b0};
        p = {1'b1, ta[22:0]} * {1'b1, tb[22:0]};
        e = 11'(ta[30:23]) + 11'(tb[30:23]) - 11'sd127;
        if (p[47])
        begin
            m  = p[47:24];
            g  = p[23];
            st = |p[22:0];
            e  = e + 11'sd1;
        end
        else
        begin
            m  = p[46:23];
            g  = p[22];
            st = |p[21:0];
        end
        return fp_round(s, e, m, g, st);
    endfunction

    // first adder half: specials, swap, align and add
    function automatic add_mid_t fp_add_align(input logic [31:0] a, input logic [31:0] b,
                                              input logic sub);
        add_mid_t    r;
        logic [31:0] ta;
        logic [31:0] tb;
        logic [31:0] big;
        logic [31:0] lit;
        logic        a_inf;
        logic        b_inf;
        logic [7:0]  d;
        logic [27:0] ma;
        logic [27:0] mb;
        logic [27:0] sh;
        logic        stk;
        ta            = fp_tidy(a);
        tb            = fp_tidy(b);
        r.special     = 1'b1;
        r.special_val = CANON_NAN;
        r.sign        = 1'b0;
        r.exp         = 11'sd0;
        r.sum         = 28'b0;
        if (ta == CANON_NAN || tb == CANON_NAN)
            return r;
        if (sub)
            tb[31] = ~tb[31];
        a_inf = ta[30:23] == 8'hFF;
        b_inf = tb[30:23] == 8'hFF;
        if (a_inf && b_inf && ta[31] != tb[31])
            return r;
        if (a_inf)
        begin
            r.special_val = ta;
            return r;
        end
        if (b_inf)
        begin
            r.special_val = tb;
            return r;
        end
        if (ta[30:23] == 8'h00 && tb[30:23] == 8'h00)
        begin
            r.special_val = {ta[31] & tb[31], 31'b0};
            return r;
        end
        if (ta[30:23] == 8'h00)
        begin
            r.special_val = tb;
            return r;
        end
        if (tb[30:23] == 8'h00)
        begin
            r.special_val = ta;
            return r;
        end
        if (ta[30:0] < tb[30:0])
        begin
            big = tb;
            lit = ta;
        end
        else
        begin
            big = ta;
            lit = tb;
        end
        d  = big[30:23] - lit[30:23];
        ma = {1'b0, 1'b1, big[22:0], 3'b0};
        mb = {1'b0, 1'b1, lit[22:0], 3'b0};
        if (d >= 8'd28)
        begin
            sh  = 28'b0;
            stk = 1'b1;
        end
        else
        begin
            sh  = mb >> d[4:0];
            stk = |(mb & ((28'd1 << d[4:0]) - 28'd1));
        end
        sh[0]     = sh[0] | stk;
        r.special = 1'b0;
        r.sign    = big[31];
        r.exp     = 11'(big[30:23]);
        r.sum     = (big[31] == lit[31]) ? ma + sh : ma - sh;
        return r;
    endfunction

    // second adder half: leading zero count, normalize, round
    function automatic logic [31:0] fp_add_norm(input add_mid_t mid);
        logic [4:0]         lz;
        logic               found;
        logic [27:0]        norm;
        logic signed [10:0] e;
        if (mid.special)
            return mid.special_val;
        if (mid.sum == 28'b0)
            return 32'h0;
        lz    = 5'd0;
        found = 1'b0;
        for (int i = 27; i >= 0; i--)
        begin
            if (!found && mid.sum[i])
            begin
                lz    = 5'(27 - i);
                found = 1'b1;
            end
        end
        norm = mid.sum << lz;
        e    = mid.exp + 11'sd1 - 11'(lz);
        return fp_round(mid.sign, e, norm[27:4], norm[3], |norm[2:0]);
    endfunction

endpackage

// ===== hdl/fvn_stream_if.sv =====
// valid/ready stream interface with a typed payload
// no dependencies
interface fvn_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/fvn_fmul.sv =====
// one-stage binary32 multiplier with registered result
// depends on fvn_pkg
module fvn_fmul (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] r
);
    import fvn_pkg::*;

    logic [31:0] r_reg;

    // product register, held on stall
    always_ff @(posedge clk)
    begin
        if (en)
            r_reg <= fp_mul(a, b);
    end

    assign r = r_reg;
endmodule

// ===== hdl/fvn_fadd.sv =====
// two-stage binary32 adder/subtractor: align and add, then normalize and round
// depends on fvn_pkg
module fvn_fadd (
    input  logic        clk,
    input  logic        en,
    input  logic        sub,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] r
);
    import fvn_pkg::*;

    add_mid_t    mid_reg;
    logic [31:0] r_reg;

    // aligned sum register
    always_ff @(posedge clk)
    begin
        if (en)
            mid_reg <= fp_add_align(a, b, sub);
    end

    // normalized result register
    always_ff @(posedge clk)
    begin
        if (en)
            r_reg <= fp_add_norm(mid_reg);
    end

    assign r = r_reg;
endmodule

// ===== hdl/fast_vector_normalize.sv =====
// fast vector normalize: ten-stage pipeline from accept to result
// throughput one transaction per cycle; a stalled output freezes the whole pipeline
// stage depth is set by one 24x24 mantissa multiply or one adder half per stage
// rst_n asynchronously clears the valid bits; payload registers are not reset
// depends on fvn_pkg, fvn_stream_if, fvn_fmul, fvn_fadd and the macros header
module fast_vector_normalize (
    input logic clk,
    input logic rst_n,
    fvn_stream_if.sink   vec,
    fvn_stream_if.source res
);
    import fvn_pkg::*;
`include "fast_vector_normalize_macros.svh"

    localparam int STAGES = 10;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic              en;
    logic [31:0]       x_pipe_reg [9];
    logic [31:0]       y_pipe_reg [9];
    logic [31:0]       e0_pipe_reg [5];
    logic [31:0]       inv_len_reg;
    logic [31:0]       xx;
    logic [31:0]       yy;
    logic [31:0]       s;
    logic [31:0]       half_s;
    logic [31:0]       a_prod;
    logic [31:0]       t_prod;
    logic [31:0]       d_diff;
    logic [31:0]       e_est;
    logic [31:0]       nx;
    logic [31:0]       ny;

    // global advance: move unless a result waits untaken
    assign en        = !v_reg[STAGES-1] || res.ready;
    assign vec.ready = en;
    assign v_next    = {v_reg[STAGES-2:0], vec.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    // operand delay lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_pipe_reg[0]  <= vec.data.x_bits;
            y_pipe_reg[0]  <= vec.data.y_bits;
            for (int i = 1; i < 9; i++)
            begin
                x_pipe_reg[i] <= x_pipe_reg[i-1];
                y_pipe_reg[i] <= y_pipe_reg[i-1];
            end
            e0_pipe_reg[0] <= MAGIC_WORD - {1'b0, s[31:1]};
            for (int i = 1; i < 5; i++)
                e0_pipe_reg[i] <= e0_pipe_reg[i-1];
            inv_len_reg    <= e_est;
        end
    end

    // squares
    fvn_fmul u_mul_xx (.clk(clk), .en(en), .a(vec.data.x_bits), .b(vec.data.x_bits), .r(xx));
    fvn_fmul u_mul_yy (.clk(clk), .en(en), .a(vec.data.y_bits), .b(vec.data.y_bits), .r(yy));

    // squared length
    fvn_fadd u_add_s (.clk(clk), .en(en), .sub(1'b0), .a(xx), .b(yy), .r(s));

    // newton step
    fvn_fmul u_mul_hs (.clk(clk), .en(en), .a(s), .b(ONE_HALF), .r(half_s));
    fvn_fmul u_mul_a (.clk(clk), .en(en), .a(half_s), .b(e0_pipe_reg[0]), .r(a_prod));
    fvn_fmul u_mul_t (.clk(clk), .en(en), .a(a_prod), .b(e0_pipe_reg[1]), .r(t_prod));
    fvn_fadd u_sub_d (.clk(clk), .en(en), .sub(1'b1), .a(THREE_HALVES), .b(t_prod),
                      .r(d_diff));
    fvn_fmul u_mul_e (.clk(clk), .en(en), .a(e0_pipe_reg[4]), .b(d_diff), .r(e_est));

    // scaled components
    fvn_fmul u_mul_nx (.clk(clk), .en(en), .a(x_pipe_reg[8]), .b(e_est), .r(nx));
    fvn_fmul u_mul_ny (.clk(clk), .en(en), .a(y_pipe_reg[8]), .b(e_est), .r(ny));

    assign res.valid             = v_reg[STAGES-1];
    assign res.data.norm_x_bits  = nx;
    assign res.data.norm_y_bits  = ny;
    assign res.data.inv_len_bits = inv_len_reg;

    // checks
    `FVN_ASSERT_IMP(a_stall_blocks, clk, rst_n, res.valid && !res.ready, !vec.ready)
    `FVN_ASSERT_IMP(a_nan_canon, clk, rst_n,
        res.valid && res.data.inv_len_bits[30:23] == 8'hFF && res.data.inv_len_bits[22:0] != 0,
        res.data.inv_len_bits == CANON_NAN)
    `FVN_ASSERT_IMP(a_no_subnormal, clk, rst_n,
        res.valid && res.data.norm_x_bits[30:23] == 8'h00,
        res.data.norm_x_bits[22:0] == 23'b0)
endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for fast_vector_normalize: directed and random vectors with random stalls
// depends on fvn_pkg, fvn_stream_if and the fast_vector_normalize top level
module tb_top;
    import fvn_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 30;

    logic clk;
    logic rst_n;

    fvn_stream_if #(.T(vec_t)) vec_ch ();
    fvn_stream_if #(.T(res_t)) res_ch ();

    fast_vector_normalize dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vec   (vec_ch.sink),
        .res   (res_ch.source)
    );

    res_t expected_norms[$];
    int   error_count;
    int   idle_cycles;
    bit   no_stall;

    // clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // binary32 arithmetic: flush subnormals, canonical nan, round to nearest even
    function automatic logic [31:0] fl_clean(input logic [31:0] b);
        if (b[30:23] == 8'h00)
            return {b[31], 31'b0};
        if (b[30:23] == 8'hFF && b[22:0] != 23'b0)
            return CANON_NAN;
        return b;
    endfunction

    // value is sig * 2^xp; sig is nonzero
    function automatic logic [31:0] fl_round(input logic s, input int xp, input logic [63:0] sig);
        int          p;
        int          be;
        int          sh;
        logic [63:0] r;
        logic        g;
        logic        st;
        p = 63;
        while (!sig[p])
            p--;
        be = xp + p + 127;
        sh = p - 23;
        if (be < 1)
            sh = sh + 1 - be;
        g  = 1'b0;
        st = 1'b0;
        if (sh >= 62)
            return {s, 31'b0};
        if (sh <= 0)
            r = sig << (-sh);
        else
        begin
            r  = sig >> sh;
            g  = sig[sh-1];
            st = |(sig & ((64'd1 << (sh - 1)) - 64'd1));
        end
        if (g && (st || r[0]))
            r = r + 64'd1;
        if (be >= 1)
        begin
            if (r[24])
            begin
                r  = r >> 1;
                be = be + 1;
            end
            if (be >= 255)
                return {s, 8'hFF, 23'b0};
            return {s, be[7:0], r[22:0]};
        end
        // subnormal range: only a carry into the smallest normal survives the flush
        return r[23] ? {s, 8'h01, 23'b0} : {s, 31'b0};
    endfunction

    function automatic logic [31:0] fl_mul(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ca;
        logic [31:0] cb;
        logic        s;
        logic        a_inf;
        logic        b_inf;
        logic        a_zero;
        logic        b_zero;
        logic [63:0] sig;
        ca     = fl_clean(a);
        cb     = fl_clean(b);
        s      = ca[31] ^ cb[31];
        a_inf  = ca[30:0] == 31'h7F800000;
        b_inf  = cb[30:0] == 31'h7F800000;
        a_zero = ca[30:23] == 8'h00;
        b_zero = cb[30:23] == 8'h00;
        if (ca == CANON_NAN || cb == CANON_NAN || (a_inf && b_zero) || (b_inf && a_zero))
            return CANON_NAN;
        if (a_inf || b_inf)
            return {s, 8'hFF, 23'b0};
        if (a_zero || b_zero)
            return {s, 31'b0};
        sig = 64'({1'b1, ca[22:0]}) * 64'({1'b1, cb[22:0]});
        return fl_round(s, int'(ca[30:23]) + int'(cb[30:23]) - 300, sig);
    endfunction

    function automatic logic [31:0] fl_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ca;
        logic [31:0] cb;
        logic [31:0] big;
        logic [31:0] lit;
        logic [63:0] mbig;
        logic [63:0] mlit;
        logic [63:0] sig;
        int          d;
        ca = fl_clean(a);
        cb = fl_clean(b);
        if (ca == CANON_NAN || cb == CANON_NAN)
            return CANON_NAN;
        if (ca[30:23] == 8'hFF && cb[30:23] == 8'hFF)
            return (ca[31] != cb[31]) ? CANON_NAN : ca;
        if (ca[30:23] == 8'hFF)
            return ca;
        if (cb[30:23] == 8'hFF)
            return cb;
        if (ca[30:23] == 8'h00 && cb[30:23] == 8'h00)
            return {ca[31] & cb[31], 31'b0};
        if (ca[30:23] == 8'h00)
            return cb;
        if (cb[30:23] == 8'h00)
            return ca;
        if (ca[30:0] < cb[30:0])
        begin
            big = cb;
            lit = ca;
        end
        else
        begin
            big = ca;
            lit = cb;
        end
        // 30 guard bits plus a sticky lsb keep the alignment exact enough
        mbig = 64'({1'b1, big[22:0]}) << 30;
        mlit = 64'({1'b1, lit[22:0]}) << 30;
        d    = int'(big[30:23]) - int'(lit[30:23]);
        if (d >= 60)
            mlit = 64'd1;
        else if (d > 0)
            mlit = (mlit >> d) | 64'(|(mlit & ((64'd1 << d) - 64'd1)));
        sig = (big[31] == lit[31]) ? mbig + mlit : mbig - mlit;
        if (sig == 64'd0)
            return 32'h0;
        return fl_round(big[31], int'(big[30:23]) - 180, sig);
    endfunction

    // expected result of one vector
    function automatic res_t predict_norm(input vec_t v);
        res_t        r;
        logic [31:0] sq;
        logic [31:0] half_sq;
        logic [31:0] est;
        logic [31:0] t;
        sq      = fl_add(fl_mul(v.x_bits, v.x_bits), fl_mul(v.y_bits, v.y_bits));
        half_sq = fl_mul(sq, ONE_HALF);
        est     = MAGIC_WORD - (fl_clean(sq) >> 1);
        t       = fl_mul(fl_mul(half_sq, est), est);
        est     = fl_mul(est, fl_add(THREE_HALVES, {~t[31], t[30:0]}));
        // negating a nan keeps it a nan after cleaning, so the subtract maps onto add
        if (fl_clean(t) == CANON_NAN)
            est = CANON_NAN;
        r.norm_x_bits  = fl_mul(v.x_bits, est);
        r.norm_y_bits  = fl_mul(v.y_bits, est);
        r.inv_len_bits = est;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %08h expected %08h", what, got, want);
        error_count++;
    endtask

    // send one vector transaction with a random gap in front
    task automatic send_vec(input logic [31:0] x, input logic [31:0] y);
        int   gap;
        vec_t v;
        gap = no_stall ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            vec_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        v.x_bits = x;
        v.y_bits = y;
        vec_ch.valid <= 1'b1;
        vec_ch.data  <= v;
        @(posedge clk);
        while (!vec_ch.ready)
            @(posedge clk);
        expected_norms.push_back(predict_norm(v));
    endtask

    task automatic end_send();
        vec_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_float(input int exp_lo, input int exp_hi);
        return {1'($urandom), 8'($urandom_range(exp_lo, exp_hi)), 23'($urandom)};
    endfunction

    // pick mostly normal operands, some with extreme exponents or special encodings
    function automatic logic [31:0] rand_operand();
        int k;
        k = $urandom_range(0, 19);
        if (k < 12)
            return rand_float(100, 154);
        if (k < 14)
            return rand_float(1, 254);
        if (k == 14)
            return {1'($urandom), 8'h00, 23'($urandom)};
        if (k == 15)
            return {1'($urandom), 8'hFF, 23'($urandom_range(0, 1) ? 23'($urandom) : 23'h0)};
        if (k == 16)
            return rand_float(1, 40);
        if (k == 17)
            return rand_float(200, 254);
        return $urandom;
    endfunction

    task automatic test_directed();
        logic [31:0] pats[16];
        pats = '{32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000,
                 32'h40400000, 32'h40800000, 32'h7F7FFFFF, 32'hFF7FFFFF,
                 32'h00800000, 32'h007FFFFF, 32'h7F800000, 32'hFF800000,
                 32'h7FC00001, 32'hFFFFFFFF, 32'h1F800000, 32'h5F800000};
        // zero vectors, a unit axis, a 3-4-5 triangle
        send_vec(32'h00000000, 32'h00000000);
        send_vec(32'h80000000, 32'h00000000);
        send_vec(32'h3F800000, 32'h00000000);
        send_vec(32'h40400000, 32'hC0800000);
        // extremes, denormals, infinities, nan, underflowing and overflowing squares
        for (int i = 0; i < 16; i++)
            send_vec(pats[i], pats[15 - i]);
        send_vec(32'h7F800000, 32'h7F800000);
        send_vec(32'h007FFFFF, 32'h807FFFFF);
        send_vec(32'h1F7FFFFF, 32'h00000000);
        send_vec(32'hFFFFFFFF, 32'h00000000);
        end_send();
    endtask

    task automatic test_random_bits(input int n);
        for (int i = 0; i < n; i++)
            send_vec($urandom, $urandom);
        end_send();
    endtask

    task automatic test_random_vectors(input int n);
        for (int i = 0; i < n; i++)
            send_vec(rand_operand(), rand_operand());
        end_send();
    endtask

    // back-to-back traffic with the sink always ready
    task automatic test_streaming(input int n);
        no_stall = 1'b1;
        for (int i = 0; i < n; i++)
            send_vec(rand_float(110, 145), rand_float(110, 145));
        end_send();
        no_stall = 1'b0;
    endtask

    // sender holds off until the pipeline has emptied
    task automatic test_drain_pause();
        test_random_vectors(20);
        wait (expected_norms.size() == 0);
        test_random_vectors(20);
    endtask

    // result sink with random stalls
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_stall ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
        end
    end

    // compare every result transaction with the oldest prediction
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_norms.size() == 0)
            begin
                $display("unexpected result %08h %08h %08h", res_ch.data.norm_x_bits,
                         res_ch.data.norm_y_bits, res_ch.data.inv_len_bits);
                error_count++;
            end
            else
            begin
                want = expected_norms.pop_front();
                if (res_ch.data.norm_x_bits !== want.norm_x_bits)
                    report_mismatch("norm_x_bits", res_ch.data.norm_x_bits, want.norm_x_bits);
                if (res_ch.data.norm_y_bits !== want.norm_y_bits)
                    report_mismatch("norm_y_bits", res_ch.data.norm_y_bits, want.norm_y_bits);
                if (res_ch.data.inv_len_bits !== want.inv_len_bits)
                    report_mismatch("inv_len_bits", res_ch.data.inv_len_bits,
                                    want.inv_len_bits);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((vec_ch.valid && vec_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        error_count  = 0;
        idle_cycles  = 0;
        no_stall     = 1'b0;
        rst_n        = 1'b0;
        vec_ch.valid = 1'b0;
        vec_ch.data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_bits(120);
        test_random_vectors(380);
        test_streaming(90);
        test_drain_pause();
        wait (expected_norms.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/fvn_pkg.sv
hdl/fvn_stream_if.sv
hdl/fvn_fmul.sv
hdl/fvn_fadd.sv
hdl/fast_vector_normalize.sv
bench/tb_top.sv
